// File: hdl/fpalu_pkg.sv
package fpalu_pkg;

  // Fixed-point format: fraction bits of a raw operand
  localparam int FRAC_BITS = 8;

  // Divider organization: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 4;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NUM_PAD    = DIV_STAGES * DIV_STEPS;

  // Operation codes
  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_SUB = 4'd1;
  localparam logic [3:0] KIND_MUL = 4'd2;
  localparam logic [3:0] KIND_DIV = 4'd3;
  localparam logic [3:0] KIND_MIN = 4'd4;
  localparam logic [3:0] KIND_MAX = 4'd5;
  localparam logic [3:0] KIND_INC = 4'd6;
  localparam logic [3:0] KIND_DEC = 4'd7;
  localparam logic [3:0] KIND_INT = 4'd8;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
    logic               divide_by_zero;
  } out_item_t;

endpackage

// File: hdl/fixed_point_alu_q24_8.sv
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, min, max, increment,
// decrement and integer part, each request giving one result with signed
// compare flags of A against B. The unit accepts one request per cycle
// while no finished result is stalled on out_ready. Every request passes
// from acceptance to the result register through one input register,
// one setup stage that forms the product and divider operands, one
// restoring-divider stage per 4 quotient bits of the 40-bit dividend, and
// the output register. All kinds take the same path, so results leave in
// request order. The whole pipeline holds while a result waits on out_ready.
module fixed_point_alu_q24_8
  import fpalu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] simple;
    logic [31:0] mulv;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        dz;
    logic        neg;
  } meta_t;

  typedef struct packed {
    logic [32:0]        rem;
    logic [NUM_PAD-1:0] num;
    logic [31:0]        quo;
    logic [31:0]        den;
  } div_t;

  logic adv;

  in_item_t in_r;
  logic     in_vld_r;

  meta_t       meta_r   [DIV_STAGES+1];
  meta_t       meta_nxt [DIV_STAGES+1];
  div_t        div_r    [DIV_STAGES+1];
  div_t        div_nxt  [DIV_STAGES+1];
  logic        vld_r    [DIV_STAGES+1];
  logic [63:0] prod_r;
  logic [63:0] prod_nxt;

  out_item_t out_r;
  out_item_t out_nxt;
  logic      out_vld_r;

  // Advance the whole pipeline unless a finished result is stalled
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // Setup stage and divider stages
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic               gt;
    logic               lt;
    logic [32:0]        rem_t;

    // Setup: flags, simple ops, product, divider operands
    a     = in_r.operand_a;
    b     = in_r.operand_b;
    gt    = a > b;
    lt    = a < b;
    mag_a = a[31] ? 32'(-a) : a;
    mag_b = b[31] ? 32'(-b) : b;

    meta_nxt[0].kind = in_r.kind;
    meta_nxt[0].gt   = gt;
    meta_nxt[0].lt   = lt;
    meta_nxt[0].eq   = (a == b);
    meta_nxt[0].dz   = (in_r.kind == KIND_DIV) && (b == 32'sd0);
    meta_nxt[0].neg  = a[31] ^ b[31];
    meta_nxt[0].mulv = '0;
    case (in_r.kind)
      KIND_ADD: meta_nxt[0].simple = a + b;
      KIND_SUB: meta_nxt[0].simple = a - b;
      KIND_MIN: meta_nxt[0].simple = lt ? a : b;
      KIND_MAX: meta_nxt[0].simple = gt ? a : b;
      KIND_INC: meta_nxt[0].simple = a + (32'sd1 <<< FRAC_BITS);
      KIND_DEC: meta_nxt[0].simple = a - (32'sd1 <<< FRAC_BITS);
      KIND_INT: meta_nxt[0].simple = a >>> FRAC_BITS;
      default:  meta_nxt[0].simple = '0;
    endcase

    prod_nxt = 64'(64'(a) * 64'(b));

    div_nxt[0].rem = '0;
    div_nxt[0].num = NUM_PAD'(mag_a) << FRAC_BITS;
    div_nxt[0].quo = '0;
    div_nxt[0].den = mag_b;

    // Divider stages: resolve DIV_STEPS quotient bits each
    for (int s = 1; s <= DIV_STAGES; s++) begin
      meta_nxt[s] = meta_r[s-1];
      div_nxt[s]  = div_r[s-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_t          = {div_nxt[s].rem[31:0], div_nxt[s].num[NUM_PAD-1]};
        div_nxt[s].num = div_nxt[s].num << 1;
        if (rem_t >= {1'b0, div_nxt[s].den}) begin
          div_nxt[s].rem = rem_t - {1'b0, div_nxt[s].den};
          div_nxt[s].quo = {div_nxt[s].quo[30:0], 1'b1};
        end else begin
          div_nxt[s].rem = rem_t;
          div_nxt[s].quo = {div_nxt[s].quo[30:0], 1'b0};
        end
      end
    end
    // Scale the product in the first divider stage
    meta_nxt[1].mulv = 32'(prod_r >>> FRAC_BITS);
  end

  // Select the final value
  always_comb begin
    meta_t m;
    m = meta_r[DIV_STAGES];
    out_nxt.a_greater      = m.gt;
    out_nxt.a_less         = m.lt;
    out_nxt.a_equal        = m.eq;
    out_nxt.divide_by_zero = m.dz;
    case (m.kind)
      KIND_MUL: out_nxt.value = m.mulv;
      KIND_DIV: begin
        if (m.dz) begin
          out_nxt.value = '0;
        end else if (m.neg) begin
          out_nxt.value = -div_r[DIV_STAGES].quo;
        end else begin
          out_nxt.value = div_r[DIV_STAGES].quo;
        end
      end
      default:  out_nxt.value = m.simple;
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int s = 0; s <= DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      in_vld_r  <= in_valid;
      vld_r[0]  <= in_vld_r;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_vld_r <= vld_r[DIV_STAGES];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r   <= in_data;
      prod_r <= prod_nxt;
      for (int s = 0; s <= DIV_STAGES; s++) begin
        meta_r[s] <= meta_nxt[s];
        div_r[s]  <= div_nxt[s];
      end
      out_r  <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
